FILE: sv/rau_pkg.sv
// Package for the rational arithmetic unit: operation and status codes, widths and the wide type.
package rau_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int MAG_W = 32;           // operand magnitude width
    localparam int WIDE_W = 2 * MAG_W + 1; // wide intermediate width
    localparam int CNT_W = 7;             // bit counter for multiply and divide

    typedef logic [WIDE_W-1:0] wide_t;
endpackage

FILE: sv/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply or divide two fractions and reduce by GCD.
// One beat at a time. Each item runs through a sequencer that drives a single
// shift-and-add/subtract datapath. It does two shift-add multiplies, plus a third for add
// and subtract, then a sum step. Then comes a Euclidean GCD in which every remainder is
// one restoring division plus a check step. Last come two divisions by the GCD and a
// finish step. There are at most about 93 Euclid steps on 64-bit values. A zero result
// skips the GCD. A zero denominator answers on the next cycle. The shared restoring
// divider sets the rate.
// s_tready is high only while the block is idle and its result register is free, so a new
// beat is taken only after the result beat has left.
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98], zero pad
    input  logic [135:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_num[31:0], res_den[62:32], status[64:63], zero pad
    output logic [71:0] m_tdata
);
    localparam int EFF_W = (OPERAND_WIDTH > 32) ? 32 : ((OPERAND_WIDTH < 8) ? 8 : OPERAND_WIDTH);
    localparam int W = rau_pkg::WIDE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_MUL3  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_GCHK  = 4'd5;
    localparam logic [3:0] S_GDIV  = 4'd6;
    localparam logic [3:0] S_QN    = 4'd7;
    localparam logic [3:0] S_QD    = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg;
    logic [31:0] res_num_reg;
    logic [30:0] res_den_reg;
    logic [1:0]  status_reg;

    logic [1:0]  mode_reg;
    logic [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        an_neg_reg, bn_neg_reg;
    logic [W-1:0] t1_reg, t2_reg, d_reg;
    logic        n_neg_reg;
    logic [W-1:0] n_reg;
    logic [W-1:0] ga_reg, gb_reg;

    // shared shift-add / restoring-divide unit
    logic [W-1:0] acc_reg;      // product accumulator or partial remainder
    logic [W-1:0] opq_reg;      // multiplier bits or dividend/quotient bits
    logic [W-1:0] opd_reg;      // multiplicand or divisor
    logic [rau_pkg::CNT_W-1:0] cnt_reg;

    function automatic logic [32:0] fmag(input logic [31:0] raw);
        logic [31:0] m;
        logic        ng;
        m = raw & ((EFF_W == 32) ? 32'hFFFF_FFFF : ((32'd1 << EFF_W) - 32'd1));
        ng = m[EFF_W-1];
        if (ng)
        begin
            m = ((EFF_W == 32) ? 32'd0 : (32'd1 << EFF_W)) - m;
        end
        return {ng, m};
    endfunction

    logic [32:0] fa_n, fa_d, fb_n, fb_d;
    assign fa_n = fmag(s_tdata[33:2]);
    assign fa_d = fmag(s_tdata[65:34]);
    assign fb_n = fmag(s_tdata[97:66]);
    assign fb_d = fmag(s_tdata[129:98]);

    logic in_fire, out_fire;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // multiplier step: multiplicand shifts left, multiplier bits shift out at bit 0
    logic [W-1:0] mul_sum;
    assign mul_sum = acc_reg + (opq_reg[0] ? opd_reg : '0);

    // divider step
    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;
    logic         rem_ge;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    assign rem_sh   = {acc_reg, opq_reg[W-1]};
    assign rem_sub  = rem_sh - {1'b0, opd_reg};
    assign rem_ge   = !rem_sub[W];
    assign rem_next = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
    assign quo_next = {opq_reg[W-2:0], rem_ge};

    logic t2_neg;
    assign t2_neg = (mode_reg == rau_pkg::OP_SUB) ? !bn_neg_reg : bn_neg_reg;

    logic mul_last, div_last;
    assign mul_last = (cnt_reg == rau_pkg::CNT_W'(31));
    assign div_last = (cnt_reg == rau_pkg::CNT_W'(W - 1));

    logic [W-1:0] lim;
    assign lim = W'(1) << (EFF_W - 1);

    logic        ovf;
    assign ovf = (d_reg > lim - W'(1)) || (n_neg_reg ? (n_reg > lim) : (n_reg > lim - W'(1)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire && fa_d[31:0] != 32'd0 && fb_d[31:0] != 32'd0 &&
                         !(s_tdata[1:0] == rau_pkg::OP_DIV && fb_n[31:0] == 32'd0))
                         state_next = S_MUL1;
            S_MUL1:  if (mul_last) state_next = S_MUL2;
            S_MUL2:  if (mul_last)
                         state_next = (mode_reg == rau_pkg::OP_MUL ||
                                       mode_reg == rau_pkg::OP_DIV) ? S_SUM : S_MUL3;
            S_MUL3:  if (mul_last) state_next = S_SUM;
            S_SUM:   state_next = S_GCHK;
            S_GCHK:  state_next = (n_reg == '0) ? S_FIN : ((gb_reg == '0) ? S_QN : S_GDIV);
            S_GDIV:  if (div_last) state_next = S_GCHK;
            S_QN:    if (div_last) state_next = S_QD;
            S_QD:    if (div_last) state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + rau_pkg::CNT_W'(1);
            if (out_fire)
                out_valid_reg <= 1'b0;
            else if ((in_fire && state_next == S_IDLE) || state_reg == S_FIN)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_reg    <= s_tdata[1:0];
                    an_reg      <= fa_n[31:0];
                    ad_reg      <= fa_d[31:0];
                    bn_reg      <= fb_n[31:0];
                    bd_reg      <= fb_d[31:0];
                    an_neg_reg  <= fa_n[32] ^ fa_d[32];
                    bn_neg_reg  <= fb_n[32] ^ fb_d[32];
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= rau_pkg::ST_ZERO_DEN;
                    acc_reg     <= '0;
                    // first product: an * bn for multiply, an * bd otherwise
                    opd_reg <= W'(fa_n[31:0]);
                    opq_reg <= (s_tdata[1:0] == rau_pkg::OP_MUL) ? W'(fb_n[31:0])
                                                                 : W'(fb_d[31:0]);
                end
            end
            S_MUL1, S_MUL2, S_MUL3:
            begin
                if (mul_last)
                begin
                    acc_reg <= '0;
                    if (state_reg == S_MUL1)
                    begin
                        t1_reg  <= mul_sum;
                        // denominator: ad * bn for divide, ad * bd otherwise
                        opd_reg <= W'(ad_reg);
                        opq_reg <= (mode_reg == rau_pkg::OP_DIV) ? W'(bn_reg) : W'(bd_reg);
                    end
                    else if (state_reg == S_MUL2)
                    begin
                        d_reg   <= mul_sum;
                        opd_reg <= W'(bn_reg);
                        opq_reg <= W'(ad_reg);
                    end
                    else
                    begin
                        t2_reg <= mul_sum;
                    end
                end
                else
                begin
                    acc_reg <= mul_sum;
                    opq_reg <= opq_reg >> 1;
                    opd_reg <= opd_reg << 1;
                end
            end
            S_SUM:
            begin
                if (mode_reg == rau_pkg::OP_MUL || mode_reg == rau_pkg::OP_DIV)
                begin
                    n_reg     <= t1_reg;
                    n_neg_reg <= an_neg_reg ^ bn_neg_reg;
                    ga_reg    <= t1_reg;
                    gb_reg    <= d_reg;
                end
                else
                begin
                    if (an_neg_reg == t2_neg)
                    begin
                        n_reg <= t1_reg + t2_reg;
                        ga_reg <= t1_reg + t2_reg;
                        n_neg_reg <= an_neg_reg;
                    end
                    else if (t1_reg >= t2_reg)
                    begin
                        n_reg <= t1_reg - t2_reg;
                        ga_reg <= t1_reg - t2_reg;
                        n_neg_reg <= an_neg_reg;
                    end
                    else
                    begin
                        n_reg <= t2_reg - t1_reg;
                        ga_reg <= t2_reg - t1_reg;
                        n_neg_reg <= t2_neg;
                    end
                    gb_reg <= d_reg;
                end
            end
            S_GCHK:
            begin
                acc_reg <= '0;
                if (gb_reg == '0)
                begin
                    opq_reg <= n_reg;
                    opd_reg <= ga_reg;
                end
                else
                begin
                    opq_reg <= ga_reg;
                    opd_reg <= gb_reg;
                end
            end
            S_GDIV, S_QN, S_QD:
            begin
                if (div_last)
                begin
                    acc_reg <= '0;
                    if (state_reg == S_GDIV)
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= rem_next;
                    end
                    else if (state_reg == S_QN)
                    begin
                        n_reg   <= quo_next;
                        opq_reg <= d_reg;
                    end
                    else
                    begin
                        d_reg <= quo_next;
                    end
                end
                else
                begin
                    acc_reg <= rem_next;
                    opq_reg <= quo_next;
                end
            end
            S_FIN:
            begin
                if (n_reg == '0)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= 31'd1;
                    status_reg  <= rau_pkg::ST_OK;
                end
                else if (ovf)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= rau_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_num_reg <= n_neg_reg ? (32'd0 - n_reg[31:0]) : n_reg[31:0];
                    res_den_reg <= d_reg[30:0];
                    status_reg  <= rau_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, status_reg, res_den_reg, res_num_reg};

    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !s_tready)
        else $error("accepted beat must block further input");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[64:63] != rau_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("error result carries numerator");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");
endmodule
